>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, register codes and beat types of the stream find and
// replace unit.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 64;
	localparam int LEN_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_PATTERN     = 8;
	localparam int DEF_MAX_REPLACEMENT = 8;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// one queued result beat
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} emit_t;

	// control shared by all window cells
	typedef struct packed {
		logic             load;
		logic [LEN_W-1:0] shift;
		logic [LEN_W-1:0] plen;
	} win_ctl_t;

	// per-cell control of the output queue
	typedef struct packed {
		logic pop;
		logic take;
		logic from_prev;
	} emit_ctl_t;

endpackage

>>> rtl/sfr_feed_if.sv
// ----------------------------------------------------------------------------
// sfr_feed_if
// Text byte channel: valid/ready handshake with one byte and a final flag.
// ----------------------------------------------------------------------------
interface sfr_feed_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::BYTE_W-1:0] data_byte;
	logic                      final_byte;

	modport source (output valid, data_byte, final_byte, input ready);
	modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

>>> rtl/sfr_result_if.sv
// ----------------------------------------------------------------------------
// sfr_result_if
// Rewritten text channel: valid/ready handshake with one byte and a flag on
// the last beat caused by an input byte.
// ----------------------------------------------------------------------------
interface sfr_result_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::BYTE_W-1:0] out_byte;
	logic                      run_last;

	modport source (output valid, out_byte, run_last, input ready);
	modport sink   (input valid, out_byte, run_last, output ready);
endinterface

>>> rtl/sfr_win_cell.sv
// ----------------------------------------------------------------------------
// sfr_win_cell
// One slot of the pending window: holds a byte, compares it against its
// pattern byte and takes its next byte from the extended window.
// ----------------------------------------------------------------------------
module sfr_win_cell #(
	parameter int IDX   = 0,
	parameter int EXT_N = sfr_pkg::DEF_MAX_PATTERN
) (
	input  logic                                  clk,
	input  sfr_pkg::win_ctl_t                     ctl,
	input  logic [EXT_N-1:0][sfr_pkg::BYTE_W-1:0] ext,
	input  logic [sfr_pkg::BYTE_W-1:0]            pat_byte,
	output logic [sfr_pkg::BYTE_W-1:0]            held,
	output logic                                  ok
);

	localparam int LW = sfr_pkg::LEN_W;

	logic [sfr_pkg::BYTE_W-1:0] byte_q;
	logic [sfr_pkg::BYTE_W-1:0] nxt;
	logic [LW-1:0]              sel;

	// slot takes the byte that sits shift places further along
	always_comb begin
		sel = LW'(IDX) + ctl.shift;
		nxt = byte_q;
		for (int k = 0; k < EXT_N; k++) begin
			if (LW'(k) == sel) begin
				nxt = ext[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= nxt;
		end
	end

	// slots past the pattern prefix never veto a match
	assign ok   = (LW'(IDX + 1) >= ctl.plen) || (byte_q == pat_byte);
	assign held = byte_q;

endmodule

>>> rtl/sfr_emit_cell.sv
// ----------------------------------------------------------------------------
// sfr_emit_cell
// One slot of the output queue: loads a new result beat or shifts toward
// the head when the head beat leaves.
// ----------------------------------------------------------------------------
module sfr_emit_cell (
	input  logic               clk,
	input  sfr_pkg::emit_ctl_t ctl,
	input  sfr_pkg::emit_t     own,
	input  sfr_pkg::emit_t     prev,
	input  sfr_pkg::emit_t     upstream,
	output sfr_pkg::emit_t     head
);

	sfr_pkg::emit_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			entry_q <= ctl.from_prev ? prev : own;
		end else if (ctl.pop) begin
			entry_q <= upstream;
		end
	end

	assign head = entry_q;

endmodule

>>> rtl/stream_find_and_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_unit
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement; matches never cross a newline.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload              | notes
//  ---------+-----+---------------------------+------------------------------
//  feed     | in  | data_byte[7:0], final_byte| one text byte per beat
//  result   | out | out_byte[7:0], run_last   | 0..MAX_OUT beats per feed beat
//  cfg      | in  | cfg_index, cfg_data[63:0] | write on cfg_we, no read-back
//
//  A feed beat is decided in the cycle it is taken; its results are registered
//  into the output queue behind any beat that stays and leave it one beat per
//  cycle while result.ready holds. A feed beat is taken whenever at most one
//  result beat is still queued, so bytes that cause one result each flow at one
//  per cycle while result.ready holds; more results per byte hold the feed.
//  Reset clears the window count, the queue count and the configuration registers; no sweep.
//  Result stalls fill the queue and then hold the feed.
// ----------------------------------------------------------------------------
module stream_find_and_replace_unit #(
	parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sfr_feed_if.sink                       feed,
	sfr_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::WORD_W-1:0]     cfg_data
);

	localparam int LW        = sfr_pkg::LEN_W;
	localparam int BW        = sfr_pkg::BYTE_W;
	localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int RPL_DEPTH = (MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1;
	localparam int MAX_OUT   = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int QD        = MAX_OUT + 1;
	localparam int PC_W      = $clog2(WIN_DEPTH + 1);
	localparam int QC_W      = $clog2(QD + 1);

	// configuration
	logic [MAX_PATTERN-1:0][BW-1:0] pat_q;
	logic [RPL_DEPTH-1:0][BW-1:0]   rpl_q;
	logic [LW-1:0]                  plen_q;
	logic [LW-1:0]                  rlen_q;
	logic [LW-1:0]                  wlen;
	logic [LW-1:0]                  plen_wr;
	logic [LW-1:0]                  rlen_wr;

	// window
	logic [PC_W-1:0]                cnt_q;
	logic [LW-1:0]                  cnt_w;
	logic [WIN_DEPTH-1:0][BW-1:0]   win_held;
	logic [WIN_DEPTH-1:0]           win_ok;
	logic [MAX_PATTERN-1:0][BW-1:0] ext;
	logic [BW-1:0]                  pat_last;
	sfr_pkg::win_ctl_t              win_ctl;

	logic          accept;
	logic          pop;
	logic          is_nl;
	logic          hit;
	logic [LW-1:0] c1;
	logic [LW-1:0] keep;
	logic [LW-1:0] pops;
	logic [LW-1:0] n;

	// result list of the current byte
	logic [MAX_OUT-1:0][BW-1:0]       ext_o;
	logic [MAX_OUT-1:0][BW-1:0]       rpl_o;
	sfr_pkg::emit_t [MAX_OUT-1:0]     list_e;

	// output queue
	logic [QC_W-1:0]                  qcnt_q;
	logic                             base;
	sfr_pkg::emit_t [QD-1:0]          q_head;

	assign accept = feed.valid && feed.ready;
	assign pop    = result.valid && result.ready;
	assign is_nl  = (feed.data_byte == sfr_pkg::NEWLINE);

	// ---------------- configuration ----------------

	assign wlen    = cfg_data[LW-1:0];
	assign plen_wr = (wlen == '0) ? LW'(1) :
		(wlen > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : wlen;
	assign rlen_wr = (wlen > LW'(MAX_REPLACEMENT)) ? LW'(MAX_REPLACEMENT) : wlen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			rpl_q  <= '0;
			plen_q <= LW'(1);
			rlen_q <= '0;
		end else if (cfg_we) begin
			case (sfr_pkg::cfg_reg_t'(cfg_index))
				sfr_pkg::REG_PATTERN_BYTES: begin
					pat_q <= cfg_data[BW*MAX_PATTERN-1:0];
				end
				sfr_pkg::REG_PATTERN_LENGTH: begin
					plen_q <= plen_wr;
				end
				sfr_pkg::REG_REPLACEMENT_BYTES: begin
					rpl_q <= cfg_data[BW*RPL_DEPTH-1:0];
				end
				sfr_pkg::REG_REPLACEMENT_LENGTH: begin
					rlen_q <= rlen_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- window cells ----------------

	assign cnt_w = LW'(cnt_q);

	// window with the incoming byte appended after the pending ones
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_ext
		if (j < WIN_DEPTH) begin : g_win
			assign ext[j] = (LW'(j) < cnt_w) ? win_held[j] : feed.data_byte;
		end else begin : g_tail
			assign ext[j] = feed.data_byte;
		end
	end

	always_comb begin
		pat_last = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (LW'(k) == plen_q - LW'(1)) begin
				pat_last = pat_q[k];
			end
		end
	end

	assign hit = !is_nl && (cnt_w == plen_q - LW'(1)) &&
		(feed.data_byte == pat_last) && (&win_ok);

	assign c1   = cnt_w + LW'(1);
	assign keep = feed.final_byte ? '0 :
		((c1 < plen_q - LW'(1)) ? c1 : plen_q - LW'(1));
	assign pops = c1 - keep;

	assign win_ctl.load  = accept && !is_nl && !hit;
	assign win_ctl.shift = pops;
	assign win_ctl.plen  = plen_q;

	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		sfr_win_cell #(
			.IDX   (i),
			.EXT_N (MAX_PATTERN)
		) u_cell (
			.clk      (clk),
			.ctl      (win_ctl),
			.ext      (ext),
			.pat_byte (pat_q[i]),
			.held     (win_held[i]),
			.ok       (win_ok[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= (is_nl || hit) ? '0 : PC_W'(keep);
		end
	end

	// ---------------- result list ----------------

	for (genvar j = 0; j < MAX_OUT; j++) begin : g_src
		if (j < MAX_PATTERN) begin : g_e
			assign ext_o[j] = ext[j];
		end else begin : g_eb
			assign ext_o[j] = feed.data_byte;
		end
		if (j < RPL_DEPTH) begin : g_r
			assign rpl_o[j] = rpl_q[j];
		end else begin : g_rz
			assign rpl_o[j] = '0;
		end
	end

	always_comb begin
		if (is_nl) begin
			n = cnt_w + LW'(!feed.final_byte);
		end else if (hit) begin
			n = rlen_q;
		end else begin
			n = pops;
		end
		for (int j = 0; j < MAX_OUT; j++) begin
			if (is_nl) begin
				list_e[j].data = (LW'(j) < cnt_w) ? ext_o[j] : sfr_pkg::NEWLINE;
			end else if (hit) begin
				list_e[j].data = rpl_o[j];
			end else begin
				list_e[j].data = ext_o[j];
			end
			list_e[j].last = (LW'(j) + LW'(1) == n);
		end
	end

	// ---------------- output queue ----------------

	assign feed.ready   = (qcnt_q <= QC_W'(1));
	assign result.valid = (qcnt_q != '0);

	// new beats go behind a head beat that stays
	assign base = (qcnt_q != '0) && !pop;

	for (genvar i = 0; i < QD; i++) begin : g_q
		sfr_pkg::emit_ctl_t qc;
		sfr_pkg::emit_t     own_e;
		sfr_pkg::emit_t     prev_e;
		sfr_pkg::emit_t     up_e;
		logic               in_rng;

		if (i < MAX_OUT) begin : g_own
			assign own_e = list_e[i];
		end else begin : g_own0
			assign own_e = '0;
		end
		if (i > 0) begin : g_prev
			assign prev_e = list_e[i-1];
			assign in_rng = base ? (LW'(i) <= n) : (LW'(i) < n);
		end else begin : g_prev0
			assign prev_e = '0;
			assign in_rng = !base && (n != '0);
		end
		if (i + 1 < QD) begin : g_up
			assign up_e = q_head[i+1];
		end else begin : g_up0
			assign up_e = '0;
		end

		assign qc.pop       = pop;
		assign qc.take      = accept && in_rng;
		assign qc.from_prev = base;

		sfr_emit_cell u_slot (
			.clk      (clk),
			.ctl      (qc),
			.own      (own_e),
			.prev     (prev_e),
			.upstream (up_e),
			.head     (q_head[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
		end else begin
			qcnt_q <= qcnt_q - QC_W'(pop) + (accept ? QC_W'(n) : '0);
		end
	end

	assign result.out_byte = q_head[0].data;
	assign result.run_last = q_head[0].last;

	// ---------------- assertions ----------------

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QC_W'(QD))
		else $error("output queue overfilled");

	a_window_fits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we |=> (LW'(cnt_q) < plen_q))
		else $error("window longer than pattern prefix after a byte");

	a_run_tail: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.run_last |-> qcnt_q > QC_W'(1))
		else $error("run of results cut short in the queue");

endmodule
